### hdl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared sizes, codes and controller/datapath interface types for the
// generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Storage sizing.
  localparam int SLOTS    = 1024;
  localparam int GEN_BITS = 16;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);

  // Field widths on the stream ports.
  localparam int IDX_FW      = 10;
  localparam int VER_FW      = 16;
  localparam int KIND_FW     = 2;
  localparam int STATUS_FW   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int IN_USED_W   = IDX_FW + VER_FW;
  localparam int OUT_USED_W  = IDX_FW + VER_FW + 1;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef enum logic [KIND_FW-1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_FW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_UNKNOWN = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // latch the incoming item
    logic pop_start;    // read the top of the free stack and shrink it
    logic alloc_new;    // hand out the next never-used index
    logic no_free;      // create with nothing left
    logic do_clear;     // empty the allocator
    logic bad_index;    // destroy or check of an index never allocated
    logic gen_direct;   // read the generation of the addressed index
    logic pop_finish;   // popped index is back, read its generation
    logic gen_finish;   // generation is back, finish the item
    logic load_out;     // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  stack_nonempty;
    logic  used_avail;
    logic  idx_known;
    logic  out_free;
  } sts_t;

endpackage

### hdl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer for the allocator: takes one item, steps it through the memory
// reads it needs, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  gha_pkg::sts_t sts,
  output gha_pkg::cmd_t cmd
);
  import gha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_GEN  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          case (sts.kind)
            KIND_CREATE: begin
              if (sts.stack_nonempty) begin
                cmd.pop_start = 1'b1;
                state_next    = S_POP;
              end else if (sts.used_avail) begin
                cmd.alloc_new = 1'b1;
                state_next    = S_RESP;
              end else begin
                cmd.no_free = 1'b1;
                state_next  = S_RESP;
              end
            end
            KIND_CLEAR: begin
              cmd.do_clear = 1'b1;
              state_next   = S_RESP;
            end
            default: begin
              if (sts.idx_known) begin
                cmd.gen_direct = 1'b1;
                state_next     = S_GEN;
              end else begin
                cmd.bad_index = 1'b1;
                state_next    = S_RESP;
              end
            end
          endcase
        end
      end
      S_POP: begin
        cmd.pop_finish = 1'b1;
        state_next     = S_GEN;
      end
      S_GEN: begin
        cmd.gen_finish = 1'b1;
        state_next     = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A result is only moved out when the output register can take it.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while output register busy");

  // A popped index always goes on to its generation read.
  a_pop_then_gen: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_start |=> cmd.pop_finish ##1 cmd.gen_finish)
    else $error("pop did not proceed to generation read");

  // Only one item is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !s_tready)
    else $error("new item taken while one is in progress");

endmodule

### hdl/gha_dp.sv
// ----------------------------------------------------------------------------
// gha_dp
// Datapath: generation memory, free stack memory, counters, result and
// output registers.
// ----------------------------------------------------------------------------
module gha_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [gha_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [gha_pkg::KIND_FW-1:0]       s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gha_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [gha_pkg::STATUS_FW-1:0]     m_tuser,
  input  gha_pkg::cmd_t                     cmd,
  output gha_pkg::sts_t                     sts
);
  import gha_pkg::*;

  logic [IDX_FW-1:0]   in_idx;
  logic [VER_FW-1:0]   in_ver;
  kind_t               op_kind;
  logic [VER_FW-1:0]   op_ver;
  logic [IDX_W-1:0]    slot;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    used_count;
  logic [IDX_FW-1:0]   res_idx;
  logic [VER_FW-1:0]   res_ver;
  logic                res_alive;
  status_t             res_status;

  logic                gen_we;
  logic [IDX_W-1:0]    gen_waddr;
  logic [GEN_BITS-1:0] gen_wdata;
  logic [IDX_W-1:0]    gen_raddr;
  logic [GEN_BITS-1:0] gen_rdata;
  logic [GEN_BITS-1:0] gen_bumped;
  logic                push;
  logic [IDX_W-1:0]    stack_raddr;
  logic [IDX_W-1:0]    stack_rdata;

  assign in_idx = s_tdata[IDX_FW-1:0];
  assign in_ver = s_tdata[IN_USED_W-1:IDX_FW];

  assign sts.kind           = kind_t'(s_tuser);
  assign sts.stack_nonempty = (free_count != '0);
  assign sts.used_avail     = (32'(used_count) < 32'(SLOTS));
  assign sts.idx_known      = (32'(in_idx) < 32'(used_count));
  assign sts.out_free       = !m_tvalid || m_tready;

  assign gen_bumped = gen_rdata + GEN_BITS'(1);
  assign push       = cmd.gen_finish && (op_kind == KIND_DESTROY) &&
                      (32'(free_count) < 32'(SLOTS));

  // Generation memory: cleared to zero on first hand-out, bumped on destroy.
  always_comb begin
    gen_we    = 1'b0;
    gen_waddr = slot;
    gen_wdata = gen_bumped;
    if (cmd.alloc_new) begin
      gen_we    = 1'b1;
      gen_waddr = used_count[IDX_W-1:0];
      gen_wdata = '0;
    end else if (cmd.gen_finish && (op_kind == KIND_DESTROY)) begin
      gen_we = 1'b1;
    end
  end

  assign gen_raddr   = cmd.gen_direct ? IDX_W'(in_idx) : stack_rdata;
  assign stack_raddr = IDX_W'(free_count - CNT_W'(1));

  gha_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (SLOTS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (push),
    .waddr (free_count[IDX_W-1:0]),
    .wdata (slot),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  // Counters and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        free_count <= '0;
        used_count <= '0;
      end
      if (cmd.pop_start) begin
        free_count <= free_count - CNT_W'(1);
      end
      if (push) begin
        free_count <= free_count + CNT_W'(1);
      end
      if (cmd.alloc_new) begin
        used_count <= used_count + CNT_W'(1);
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Operand, result and output payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_kind <= kind_t'(s_tuser);
      op_ver  <= in_ver;
      slot    <= IDX_W'(in_idx);
    end
    if (cmd.pop_finish) begin
      slot <= stack_rdata;
    end
    if (cmd.alloc_new) begin
      res_idx    <= IDX_FW'(used_count[IDX_W-1:0]);
      res_ver    <= '0;
      res_alive  <= 1'b0;
      res_status <= STATUS_OK;
    end
    if (cmd.no_free || cmd.do_clear) begin
      res_idx    <= '0;
      res_ver    <= '0;
      res_alive  <= 1'b0;
      res_status <= cmd.no_free ? STATUS_FULL : STATUS_OK;
    end
    if (cmd.bad_index) begin
      res_idx    <= in_idx;
      res_ver    <= '0;
      res_alive  <= 1'b0;
      res_status <= STATUS_UNKNOWN;
    end
    if (cmd.gen_finish) begin
      res_idx    <= IDX_FW'(slot);
      res_ver    <= (op_kind == KIND_DESTROY) ? VER_FW'(gen_bumped) : VER_FW'(gen_rdata);
      res_alive  <= (op_kind == KIND_CHECK) && (32'(gen_rdata) == 32'(op_ver));
      res_status <= STATUS_OK;
    end
    if (cmd.load_out) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, res_alive, res_ver, res_idx};
      m_tuser <= res_status;
    end
  end

  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(free_count) <= 32'(SLOTS))
    else $error("free stack count beyond capacity");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(used_count) <= 32'(SLOTS))
    else $error("used count beyond capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_start |-> (free_count != '0))
    else $error("pop from empty free stack");

  a_alive_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_USED_W-1]) |-> (m_tuser == STATUS_OK))
    else $error("alive reported with error status");

endmodule

### hdl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out handles made of a slot index and a generation. An item on the
// input stream is a request: create, destroy, check or clear, chosen by
// s_tuser. Create reuses the most recently destroyed index from a LIFO free
// stack and otherwise takes the next never-used index, whose generation
// starts at zero. Destroy bumps the slot generation (wrapping) and pushes the
// index back on the stack unless the stack is full; check tells whether a
// handle generation still matches the slot; clear forgets every slot. Every
// request yields exactly one result item. One request is worked on at a time
// and the next is taken as soon as the previous result sits in the output
// register, even if that result has not yet been taken downstream. The steps
// of an item, from accept to the next accept, are set by the dependent
// synchronous reads of the free stack memory and then the generation memory:
// a reusing create has stack read, generation read, result; destroy or check
// of a known index has generation read, result; a fresh create, a create with
// nothing free, a clear, or a request naming an index never handed out has
// only the result. A stalled output holds the result step. No clearing pass
// is needed after reset: only entries below the fill counts are ever read.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
  input  logic                             clk,
  input  logic                             rst,
  // Request channel.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [9:0] handle_index, [25:10] handle_version, [31:26] zero
  input  logic [gha_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [1:0] kind
  input  logic [gha_pkg::KIND_FW-1:0]      s_tuser,
  // Result channel.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [9:0] slot_index, [25:10] slot_version, [26] alive, [31:27] zero
  output logic [gha_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // [1:0] status
  output logic [gha_pkg::STATUS_FW-1:0]    m_tuser
);
  import gha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each request; it never touches data.
  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds both memories, the counters and the output register.
  gha_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

### tb/generational_handle_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_test
// Self-checking regression for the handle allocator. Request items go in with
// random gaps and results come out under random backpressure. Every accepted
// request is run through a software copy of the slot generations and of the
// LIFO free stack, and each returned result is compared field by field with
// the oldest outstanding prediction. A short directed table covers the corner
// cases; the biased random traffic that follows mostly uses live handles.
// ----------------------------------------------------------------------------
module generational_handle_allocator_test;
  import gha_pkg::*;

  // One result item, as it travels on m_tdata and m_tuser.
  typedef struct packed {
    status_t         status;
    logic            alive;
    logic [VER_FW-1:0] ver;
    logic [IDX_FW-1:0] idx;
  } slot_result_t;

  // One line of the directed table. A request is sent reps times in a row.
  // When typed is set, want holds the answer that is obvious by inspection.
  typedef struct packed {
    kind_t             kind;
    logic [IDX_FW-1:0] idx;
    logic [VER_FW-1:0] ver;
    logic [16:0]       reps;
    logic              typed;
    slot_result_t      want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [KIND_FW-1:0]     s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_FW-1:0]   m_tuser;

  // Shadow copy of the allocator state.
  logic [GEN_BITS-1:0] gen_mem  [SLOTS];
  logic [IDX_W-1:0]    free_mem [SLOTS];
  int unsigned         n_free = 0;
  int unsigned         n_used = 0;

  slot_result_t awaited_answers[$];
  bit           failed = 1'b0;
  bit           calm = 1'b0;   // no idling on either side while set
  int unsigned  ready_hold = 0;

  always #1 clk = ~clk;

  generational_handle_allocator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Gap length for either side: mostly none, sometimes short, and now and then
  // a long pause.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic slot_result_t outcome(status_t st, logic [IDX_FW-1:0] i,
                                           logic [VER_FW-1:0] v, logic a);
    slot_result_t r;
    r.status = st;
    r.alive  = a;
    r.ver    = v;
    r.idx    = i;
    return r;
  endfunction

  function automatic stim_row_t step_row(kind_t k, logic [IDX_FW-1:0] i,
                                         logic [VER_FW-1:0] v, int reps,
                                         logic typed, slot_result_t w);
    stim_row_t r;
    r.kind  = k;
    r.idx   = i;
    r.ver   = v;
    r.reps  = 17'(reps);
    r.typed = typed;
    r.want  = w;
    return r;
  endfunction

  // Applies one request to the shadow state and returns the answer it earns.
  function automatic slot_result_t allocator_answer(kind_t k, logic [IDX_FW-1:0] hidx,
                                                    logic [VER_FW-1:0] hver);
    slot_result_t     r;
    logic [IDX_W-1:0] slot;
    r = outcome(STATUS_OK, '0, '0, 1'b0);
    case (k)
      KIND_CREATE: begin
        if (n_free != 0) begin
          // Most recently freed index goes out first.
          n_free--;
          slot  = free_mem[IDX_W'(n_free)];
          r.idx = slot;
          r.ver = gen_mem[slot];
        end else if (n_used < SLOTS) begin
          // Fresh index, its generation starts over at zero.
          slot          = IDX_W'(n_used);
          gen_mem[slot] = '0;
          n_used++;
          r.idx = slot;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      KIND_CLEAR: begin
        n_free = 0;
        n_used = 0;
      end
      default: begin
        r.idx = hidx;
        if (hidx >= n_used) begin
          r.status = STATUS_UNKNOWN;
        end else if (k == KIND_DESTROY) begin
          // The generation always advances; the push is lost on a full stack.
          gen_mem[hidx] = gen_mem[hidx] + 1'b1;
          if (n_free < SLOTS) begin
            free_mem[IDX_W'(n_free)] = hidx;
            n_free++;
          end
          r.ver = gen_mem[hidx];
        end else begin
          r.ver   = gen_mem[hidx];
          r.alive = (gen_mem[hidx] == hver);
        end
      end
    endcase
    return r;
  endfunction

  // Presents one request, waits for the handshake, then records its answer.
  task automatic issue(kind_t k, logic [IDX_FW-1:0] hidx, logic [VER_FW-1:0] hver,
                       logic typed, slot_result_t want);
    int unsigned  gap;
    slot_result_t guess;
    gap = idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, hver, hidx};
    do @(posedge clk); while (!s_tready);
    guess = allocator_answer(k, hidx, hver);
    awaited_answers = {awaited_answers, (typed ? want : guess)};
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Result side: check every accepted item and throttle m_tready.
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: result item with nothing expected, tdata %h tuser %0d",
                 $time, m_tdata, m_tuser);
        failed = 1'b1;
      end else begin
        want = awaited_answers.pop_front();
        compare_field("slot_index", 32'(want.idx), 32'(m_tdata[9:0]));
        compare_field("slot_version", 32'(want.ver), 32'(m_tdata[25:10]));
        compare_field("alive", 32'(want.alive), 32'(m_tdata[26]));
        compare_field("status", 32'(want.status), 32'(m_tuser));
      end
      ready_hold = idle_len();
    end else if (ready_hold != 0) begin
      ready_hold--;
    end
    m_tready <= (ready_hold == 0);
  end

  initial begin
    stim_row_t    plan [21];
    slot_result_t none;
    kind_t        k;
    logic [IDX_FW-1:0] hidx;
    logic [VER_FW-1:0] hver;
    int unsigned  pick;
    int unsigned  drain;

    none = outcome(STATUS_OK, '0, '0, 1'b0);
    // Directed table. Rows marked typed carry their answer; the rest, and the
    // runs in particular, are predicted.
    plan[0]  = step_row(KIND_CREATE, 10'd0, 16'd0, 1, 1'b1,
                        outcome(STATUS_OK, 10'd0, 16'd0, 1'b0));
    plan[1]  = step_row(KIND_CHECK, 10'd0, 16'd0, 1, 1'b1,
                        outcome(STATUS_OK, 10'd0, 16'd0, 1'b1));
    // Index never handed out, for check and for destroy at the top index.
    plan[2]  = step_row(KIND_CHECK, 10'd1, 16'd0, 1, 1'b1,
                        outcome(STATUS_UNKNOWN, 10'd1, 16'd0, 1'b0));
    plan[3]  = step_row(KIND_DESTROY, 10'd1023, 16'hFFFF, 1, 1'b1,
                        outcome(STATUS_UNKNOWN, 10'd1023, 16'd0, 1'b0));
    plan[4]  = step_row(KIND_CHECK, 10'd0, 16'hFFFF, 1, 1'b1,
                        outcome(STATUS_OK, 10'd0, 16'd0, 1'b0));
    plan[5]  = step_row(KIND_DESTROY, 10'd0, 16'd0, 1, 1'b1,
                        outcome(STATUS_OK, 10'd0, 16'd1, 1'b0));
    plan[6]  = step_row(KIND_CHECK, 10'd0, 16'd1, 1, 1'b1,
                        outcome(STATUS_OK, 10'd0, 16'd1, 1'b1));
    // Create reuses the freed index with its new generation.
    plan[7]  = step_row(KIND_CREATE, 10'd0, 16'd0, 1, 1'b1,
                        outcome(STATUS_OK, 10'd0, 16'd1, 1'b0));
    plan[8]  = step_row(KIND_CREATE, 10'd0, 16'd0, 1, 1'b1,
                        outcome(STATUS_OK, 10'd1, 16'd0, 1'b0));
    // Repeated destroy of one slot: the generation keeps advancing and the
    // same index lands on the stack once per destroy.
    plan[9]  = step_row(KIND_DESTROY, 10'd0, 16'd0, 3, 1'b0, none);
    plan[10] = step_row(KIND_CHECK, 10'd0, 16'd4, 1, 1'b1,
                        outcome(STATUS_OK, 10'd0, 16'd4, 1'b1));
    plan[11] = step_row(KIND_CREATE, 10'd0, 16'd0, 3, 1'b0, none);
    plan[12] = step_row(KIND_CREATE, 10'd0, 16'd0, 1, 1'b1,
                        outcome(STATUS_OK, 10'd2, 16'd0, 1'b0));
    plan[13] = step_row(KIND_CLEAR, 10'd1023, 16'hFFFF, 1, 1'b1, none);
    plan[14] = step_row(KIND_CHECK, 10'd0, 16'd0, 1, 1'b1,
                        outcome(STATUS_UNKNOWN, 10'd0, 16'd0, 1'b0));
    // After a clear, a fresh index starts over at generation zero.
    plan[15] = step_row(KIND_CREATE, 10'd1023, 16'hFFFF, 1, 1'b1,
                        outcome(STATUS_OK, 10'd0, 16'd0, 1'b0));
    plan[16] = step_row(KIND_CREATE, 10'd0, 16'd0, 3, 1'b0, none);
    plan[17] = step_row(KIND_CHECK, 10'd3, 16'd0, 1, 1'b1,
                        outcome(STATUS_OK, 10'd3, 16'd0, 1'b1));
    plan[18] = step_row(KIND_DESTROY, 10'd3, 16'hFFFF, 1, 1'b1,
                        outcome(STATUS_OK, 10'd3, 16'd1, 1'b0));
    plan[19] = step_row(KIND_CREATE, 10'd0, 16'd0, 1, 1'b1,
                        outcome(STATUS_OK, 10'd3, 16'd1, 1'b0));
    plan[20] = step_row(KIND_CLEAR, 10'd0, 16'd0, 1, 1'b1, none);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < 21; r++) begin
      for (int n = 0; n < plan[r].reps; n++) begin
        issue(plan[r].kind, plan[r].idx, plan[r].ver, plan[r].typed, plan[r].want);
      end
    end

    // Random traffic, biased toward handles that are live so that the free
    // stack keeps getting reused. A small share is noise and clears.
    for (int i = 0; i < 800; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      hidx = IDX_FW'($urandom_range(0, SLOTS - 1));
      hver = VER_FW'($urandom_range(0, 65535));
      if (pick < 35) begin
        k = KIND_CREATE;
      end else if (pick < 98) begin
        if (pick < 62) k = KIND_DESTROY;
        else k = KIND_CHECK;
        if (n_used != 0 && $urandom_range(0, 9) < 8) begin
          hidx = IDX_FW'($urandom_range(0, n_used - 1));
          case ($urandom_range(0, 3))
            0, 1: hver = gen_mem[hidx];
            2: hver = gen_mem[hidx] + 1'b1;
            default: hver = hver;
          endcase
        end
      end else begin
        k = KIND_CLEAR;
      end
      issue(k, hidx, hver, 1'b0, none);
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    // Drain the outstanding results, then keep the clock running so that any
    // stray item shows.
    drain = 0;
    while (awaited_answers.size() != 0 && drain < 4000) begin
      @(posedge clk);
      drain++;
    end
    repeat (16) @(posedge clk);
    if (awaited_answers.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               awaited_answers.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("generational_handle_allocator regression: pass");
    end else begin
      $display("generational_handle_allocator regression: fail");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #60ms;
    $display("%0t: timeout", $time);
    $display("generational_handle_allocator regression: fail");
    $finish;
  end

endmodule

### filelist.f
hdl/gha_pkg.sv
hdl/gha_ram.sv
hdl/gha_ctrl.sv
hdl/gha_dp.sv
hdl/generational_handle_allocator.sv
tb/generational_handle_allocator_test.sv
